### sv/dense_keyed_table_swap_remove_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dense keyed table core
// Clocked property wrappers used by the core file that checks this block.
// ----------------------------------------------------------------------------
`ifndef DENSE_KEYED_TABLE_SWAP_REMOVE_CORE_ASSERT_SVH
`define DENSE_KEYED_TABLE_SWAP_REMOVE_CORE_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define DKT_ASSERT_HOLDS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

// When the first expression holds, the second holds in the following cycle.
`define DKT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/dkt_pkg.sv
// ----------------------------------------------------------------------------
// Dense keyed table package
// Field widths, operation and status codes, and controller interface types.
// ----------------------------------------------------------------------------
package dkt_pkg;

  localparam int DEF_TABLE_DEPTH   = 1024;
  localparam int DEF_PAYLOAD_WIDTH = 64;
  localparam int DEF_KEY_WIDTH     = 32;

  localparam int FUNC_W      = 3;
  localparam int KEY_IN_W    = 32;
  localparam int DATA_IN_W   = 64;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 11;

  localparam logic [FUNC_W-1:0] FN_ADD_AUTO = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ADD_KEY  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_CHANGE   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REMOVE   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_QUERY    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CLEAR    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXISTS    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic                load;
    logic                scan;
    logic                add;
    logic                change;
    logic                capture_read;
    logic                rm_read;
    logic                rm_write;
    logic                clear;
    logic                set_status;
    logic [STATUS_W-1:0] status_code;
    logic                respond;
  } dkt_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              hit;
    logic              issue;
    logic              full;
    logic              out_free;
  } dkt_stat_t;

endpackage

### sv/dkt_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries one operation word with valid and ready.
// ----------------------------------------------------------------------------
interface dkt_req_if import dkt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [KEY_IN_W-1:0]  key;
  logic [DATA_IN_W-1:0] entry_data;

  modport source (output valid, func, key, entry_data, input ready);
  modport sink (input valid, func, key, entry_data, output ready);
endinterface

### sv/dkt_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Carries one result word with valid and ready.
// ----------------------------------------------------------------------------
interface dkt_rsp_if import dkt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [KEY_IN_W-1:0]    assigned_key;
  logic [DATA_IN_W-1:0]   read_data;
  logic [COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, status, assigned_key, read_data, entry_count, input ready);
  modport sink (input valid, status, assigned_key, read_data, entry_count, output ready);
endinterface

### sv/dense_keyed_table_swap_remove_core.sv
// ----------------------------------------------------------------------------
// Dense keyed table with swap-remove
// Keys and payloads sit packed in slots 0 to count minus 1 of two memories.
// One operation word is taken at a time and gives exactly one result word.
// A key lookup reads the key memory through its single read port, one slot
// per cycle in slot order, so a lookup that finds its key at slot j reads
// slots 0 to j and a miss reads all count slots. A remove then reads the
// last entry and moves it into the freed slot. Clear, unused codes and an
// automatic add to a full table go from dispatch straight to the response.
// The next word is accepted in the cycle after the result is loaded into the
// output register, whether or not that result has been taken.
// ----------------------------------------------------------------------------
`include "dense_keyed_table_swap_remove_core_assert.svh"

module dense_keyed_table_swap_remove_core import dkt_pkg::*; #(
  parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
  parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH,
  parameter int KEY_WIDTH     = DEF_KEY_WIDTH
) (
  input logic       clk,
  input logic       rst,
  dkt_req_if.sink   req,
  dkt_rsp_if.source rsp
);

  dkt_cmd_t  cmd;
  dkt_stat_t stat;

  dkt_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dkt_datapath #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
    .KEY_WIDTH     (KEY_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .in_func          (req.func),
    .in_key           (req.key),
    .in_entry_data    (req.entry_data),
    .out_ready        (rsp.ready),
    .out_valid        (rsp.valid),
    .out_status       (rsp.status),
    .out_assigned_key (rsp.assigned_key),
    .out_read_data    (rsp.read_data),
    .out_entry_count  (rsp.entry_count)
  );

  `DKT_ASSERT_NEXT(a_one_in_flight, clk, rst, req.valid && req.ready, !req.ready, "word accepted while another is in flight")
  `DKT_ASSERT_HOLDS(a_respond_free, clk, rst, !cmd.respond || !rsp.valid || rsp.ready, "result overwrites an untaken word")
  `DKT_ASSERT_HOLDS(a_one_write, clk, rst, $onehot0({cmd.add, cmd.change, cmd.rm_write}), "conflicting memory writes")
  `DKT_ASSERT_HOLDS(a_count_bound, clk, rst, !rsp.valid || (rsp.entry_count <= COUNT_OUT_W'(TABLE_DEPTH)), "entry count beyond depth")

endmodule

### sv/dkt_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/dkt_datapath.sv
// ----------------------------------------------------------------------------
// Dense keyed table datapath
// Key and payload memories, counters, slot scan and the result register.
// ----------------------------------------------------------------------------
module dkt_datapath import dkt_pkg::*; #(
  parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
  parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH,
  parameter int KEY_WIDTH     = DEF_KEY_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dkt_cmd_t               cmd,
  output dkt_stat_t              stat,
  input  logic [FUNC_W-1:0]      in_func,
  input  logic [KEY_IN_W-1:0]    in_key,
  input  logic [DATA_IN_W-1:0]   in_entry_data,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [STATUS_W-1:0]    out_status,
  output logic [KEY_IN_W-1:0]    out_assigned_key,
  output logic [DATA_IN_W-1:0]   out_read_data,
  output logic [COUNT_OUT_W-1:0] out_entry_count
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [FUNC_W-1:0]        op_func;
  logic [KEY_WIDTH-1:0]     op_key;
  logic [PAYLOAD_WIDTH-1:0] op_data;
  logic [CW-1:0]            count;
  logic [KEY_WIDTH-1:0]     next_key;
  logic [CW-1:0]            scan_idx;
  logic                     pend;
  logic [AW-1:0]            pend_idx;
  logic [STATUS_W-1:0]      res_status;
  logic [KEY_WIDTH-1:0]     res_assigned;
  logic [PAYLOAD_WIDTH-1:0] res_rdata;

  logic [KEY_WIDTH-1:0]     lookup_key;
  logic [KEY_WIDTH-1:0]     key_inc;
  logic [CW-1:0]            count_dec;
  logic                     issue;
  logic                     auto_add;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            wr_addr;
  logic                     key_we;
  logic [KEY_WIDTH-1:0]     key_wd;
  logic [KEY_WIDTH-1:0]     key_rd;
  logic                     pay_we;
  logic [PAYLOAD_WIDTH-1:0] pay_wd;
  logic [PAYLOAD_WIDTH-1:0] pay_rd;

  assign auto_add   = (op_func == FN_ADD_AUTO);
  assign lookup_key = auto_add ? next_key : op_key;
  assign key_inc    = op_key + KEY_WIDTH'(1);
  assign count_dec  = count - CW'(1);
  assign issue      = (scan_idx < count);

  assign rd_addr = cmd.rm_read ? count_dec[AW-1:0] : scan_idx[AW-1:0];
  assign wr_addr = cmd.add ? count[AW-1:0] : pend_idx;
  assign key_we  = cmd.add | cmd.rm_write;
  assign key_wd  = cmd.rm_write ? key_rd : lookup_key;
  assign pay_we  = cmd.add | cmd.change | cmd.rm_write;
  assign pay_wd  = cmd.rm_write ? pay_rd : op_data;

  assign stat.func     = op_func;
  assign stat.hit      = pend && (key_rd == lookup_key);
  assign stat.issue    = issue;
  assign stat.full     = (count == CW'(TABLE_DEPTH));
  assign stat.out_free = !out_valid || out_ready;

  dkt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (wr_addr),
    .wr_data (key_wd),
    .rd_addr (rd_addr),
    .rd_data (key_rd)
  );

  dkt_ram #(.WIDTH(PAYLOAD_WIDTH), .DEPTH(TABLE_DEPTH)) u_payload_ram (
    .clk     (clk),
    .wr_en   (pay_we),
    .wr_addr (wr_addr),
    .wr_data (pay_wd),
    .rd_addr (rd_addr),
    .rd_data (pay_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      next_key  <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        pend <= 1'b0;
      end else if (cmd.scan) begin
        pend <= issue;
      end
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.add) begin
        count <= count + CW'(1);
      end else if (cmd.rm_write) begin
        count <= count_dec;
      end
      if (cmd.add) begin
        if (auto_add) begin
          next_key <= next_key + KEY_WIDTH'(1);
        end else if (key_inc > next_key) begin
          next_key <= key_inc;
        end
      end
      if (cmd.respond) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func      <= in_func;
      op_key       <= KEY_WIDTH'(in_key);
      op_data      <= PAYLOAD_WIDTH'(in_entry_data);
      scan_idx     <= '0;
      res_status   <= ST_OK;
      res_assigned <= '0;
      res_rdata    <= '0;
    end else begin
      if (cmd.scan && issue) begin
        scan_idx <= scan_idx + CW'(1);
        pend_idx <= scan_idx[AW-1:0];
      end
      if (cmd.set_status) begin
        res_status <= cmd.status_code;
      end
      if (cmd.add && auto_add) begin
        res_assigned <= next_key;
      end
      if (cmd.capture_read) begin
        res_rdata <= pay_rd;
      end
    end
    if (cmd.respond) begin
      out_status       <= res_status;
      out_assigned_key <= KEY_IN_W'(res_assigned);
      out_read_data    <= DATA_IN_W'(res_rdata);
      out_entry_count  <= COUNT_OUT_W'(count);
    end
  end

endmodule

### sv/dkt_controller.sv
// ----------------------------------------------------------------------------
// Dense keyed table controller
// Sequences dispatch, slot scan, swap-remove and the response of one word.
// ----------------------------------------------------------------------------
module dkt_controller import dkt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dkt_stat_t stat,
  output dkt_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_SCAN     = 6'b000100,
    S_RM_READ  = 6'b001000,
    S_RM_WRITE = 6'b010000,
    S_RESP     = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.status_code = ST_OK;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.func)
          FN_ADD_AUTO: begin
            if (stat.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
              state_next      = S_RESP;
            end else begin
              state_next = S_SCAN;
            end
          end
          FN_ADD_KEY, FN_CHANGE, FN_REMOVE, FN_QUERY: begin
            state_next = S_SCAN;
          end
          FN_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_RESP;
          end
          default: begin
            state_next = S_RESP;
          end
        endcase
      end
      S_SCAN: begin
        if (stat.hit) begin
          state_next = S_RESP;
          case (stat.func)
            FN_ADD_AUTO, FN_ADD_KEY: begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_EXISTS;
            end
            FN_CHANGE: begin
              cmd.change = 1'b1;
            end
            FN_REMOVE: begin
              state_next = S_RM_READ;
            end
            FN_QUERY: begin
              cmd.capture_read = 1'b1;
            end
            default: begin
            end
          endcase
        end else if (!stat.issue) begin
          state_next = S_RESP;
          case (stat.func)
            FN_ADD_AUTO: begin
              cmd.add = 1'b1;
            end
            FN_ADD_KEY: begin
              if (stat.full) begin
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_FULL;
              end else begin
                cmd.add = 1'b1;
              end
            end
            FN_CHANGE, FN_REMOVE, FN_QUERY: begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_NOT_FOUND;
            end
            default: begin
            end
          endcase
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_RM_READ: begin
        cmd.rm_read = 1'b1;
        state_next  = S_RM_WRITE;
      end
      S_RM_WRITE: begin
        cmd.rm_write = 1'b1;
        state_next   = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.respond = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
